// ===== src/tba3_pkg.sv =====
// Shared constants and types of the toroidal 3x3 box average unit.
package tba3_pkg;

  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ADDR_W   = ROW_W + COL_W;
  localparam int unsigned DEPTH    = MAX_ROWS * MAX_COLS;

  localparam int unsigned PIX_W  = 16;
  localparam int unsigned DIM_W  = 7;
  localparam int unsigned SUM_W  = 20;
  localparam int unsigned MAG_W  = 19;

  // Reciprocal of nine, exact for magnitudes below 2**25 / 63.
  localparam int unsigned RECIP_SHIFT = 25;
  localparam int unsigned RECIP_W     = 22;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 22'd3728271;
  localparam int unsigned PROD_W      = MAG_W + RECIP_W;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [0:0] {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_kind_t;

endpackage

// ===== src/toroidal_box_average_3x3_unit.sv =====
// Top level of the toroidal 3x3 box average unit: frame store and read sequencer.
//
// A request word is taken at a rising edge with start high and busy low. A
// write word stores pixel_value at (row_index, col_index) in that same cycle
// and leaves busy low, so writes may follow every cycle. A read word raises
// busy; the nine wrapped neighbours are fetched one per cycle from the single
// port of the frame store, summed, and divided by nine with a reciprocal
// multiply. The result word appears on average_value for exactly one cycle
// with done high, after the fetch, drain, magnitude and multiply states (when
// the frame is narrower than three rows or columns, only the centre is read
// and its value is returned without the multiply). busy falls in the cycle
// after done. The single port of the frame store sets the fetch time.
// Requests outside the configured frame are dropped at once.
// The receiver cannot stall, so no result is ever held back.
// Registers frame_rows (address 0) and frame_cols (address 4) sit on the
// APB port and reset to 64. Reset clears the sequencer; the frame store is
// not cleared, and only written pixels may be read.
module toroidal_box_average_3x3_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic [tba3_pkg::ROW_W-1:0]          row_index,
  input  logic [tba3_pkg::COL_W-1:0]          col_index,
  input  logic signed [tba3_pkg::PIX_W-1:0]   pixel_value,
  output logic                                done,
  output logic signed [tba3_pkg::PIX_W-1:0]   average_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tba3_pkg::PADDR_W-1:0]        paddr,
  input  logic [tba3_pkg::PDATA_W-1:0]        pwdata,
  output logic [tba3_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_MAG   = 6'b001000,
    S_MUL   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [tba3_pkg::DIM_W-1:0] frame_rows;
  logic [tba3_pkg::DIM_W-1:0] frame_cols;
  logic [tba3_pkg::DIM_W-1:0] eff_rows;
  logic [tba3_pkg::DIM_W-1:0] eff_cols;

  logic accept;
  logic in_frame;
  logic narrow_now;
  logic wr_go;
  logic rd_go;

  logic [tba3_pkg::ROW_W-1:0] row_up;
  logic [tba3_pkg::ROW_W-1:0] row_dn;
  logic [tba3_pkg::COL_W-1:0] col_lt;
  logic [tba3_pkg::COL_W-1:0] col_rt;

  logic [tba3_pkg::ROW_W-1:0] rows [3];
  logic [tba3_pkg::COL_W-1:0] cols [3];
  logic [1:0]                 dr;
  logic [1:0]                 dc;
  logic                       narrow;
  logic                       last_issue;
  logic                       rd_vld;

  logic                              ram_we;
  logic [tba3_pkg::ADDR_W-1:0]       ram_addr;
  logic [tba3_pkg::PIX_W-1:0]        ram_rdata;

  logic signed [tba3_pkg::SUM_W-1:0] sum;
  logic [tba3_pkg::MAG_W-1:0]        mag;
  logic                              neg;
  logic [tba3_pkg::PROD_W-1:0]       prod;
  logic [tba3_pkg::PIX_W-1:0]        quot;

  logic cfg_we;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= tba3_pkg::DIM_W'(tba3_pkg::MAX_ROWS);
      frame_cols <= tba3_pkg::DIM_W'(tba3_pkg::MAX_COLS);
    end else if (cfg_we) begin
      unique case (tba3_pkg::reg_index_t'(paddr[2]))
        tba3_pkg::REG_FRAME_ROWS: frame_rows <= pwdata[tba3_pkg::DIM_W-1:0];
        tba3_pkg::REG_FRAME_COLS: frame_cols <= pwdata[tba3_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (tba3_pkg::reg_index_t'(paddr[2]))
      tba3_pkg::REG_FRAME_ROWS:
        prdata = tba3_pkg::PDATA_W'(frame_rows);
      tba3_pkg::REG_FRAME_COLS:
        prdata = tba3_pkg::PDATA_W'(frame_cols);
      default:
        prdata = '0;
    endcase
  end

  // Request decode and wrapped neighbour positions.
  assign eff_rows = (frame_rows > tba3_pkg::DIM_W'(tba3_pkg::MAX_ROWS))
                    ? tba3_pkg::DIM_W'(tba3_pkg::MAX_ROWS) : frame_rows;
  assign eff_cols = (frame_cols > tba3_pkg::DIM_W'(tba3_pkg::MAX_COLS))
                    ? tba3_pkg::DIM_W'(tba3_pkg::MAX_COLS) : frame_cols;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign in_frame   = (tba3_pkg::DIM_W'(row_index) < eff_rows)
                   && (tba3_pkg::DIM_W'(col_index) < eff_cols);
  assign narrow_now = (eff_rows < tba3_pkg::DIM_W'(3)) || (eff_cols < tba3_pkg::DIM_W'(3));
  assign wr_go      = accept && in_frame && (req_type == tba3_pkg::REQ_WRITE);
  assign rd_go      = accept && in_frame && (req_type == tba3_pkg::REQ_READ);

  assign row_up = (row_index == '0) ? tba3_pkg::ROW_W'(eff_rows - 1'b1)
                                    : row_index - 1'b1;
  assign row_dn = ((tba3_pkg::DIM_W'(row_index) + 1'b1) == eff_rows) ? '0
                                    : row_index + 1'b1;
  assign col_lt = (col_index == '0) ? tba3_pkg::COL_W'(eff_cols - 1'b1)
                                    : col_index - 1'b1;
  assign col_rt = ((tba3_pkg::DIM_W'(col_index) + 1'b1) == eff_cols) ? '0
                                    : col_index + 1'b1;

  always_ff @(posedge clk) begin
    if (rd_go) begin
      rows[0] <= row_up;
      rows[1] <= row_index;
      rows[2] <= row_dn;
      cols[0] <= col_lt;
      cols[1] <= col_index;
      cols[2] <= col_rt;
      narrow  <= narrow_now;
    end
  end

  // Frame store.
  assign ram_we   = wr_go;
  assign ram_addr = (state == S_SCAN) ? {rows[dr], cols[dc]} : {row_index, col_index};

  tba3_ram #(
    .WIDTH (tba3_pkg::PIX_W),
    .DEPTH (tba3_pkg::DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pixel_value),
    .rdata (ram_rdata)
  );

  // Sequencer.
  assign last_issue = narrow || ((dr == 2'd2) && (dc == 2'd2));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (rd_go) state_next = S_SCAN;
      S_SCAN:  if (last_issue) state_next = S_DRAIN;
      S_DRAIN: state_next = S_MAG;
      S_MAG:   state_next = narrow ? S_OUT : S_MUL;
      S_MUL:   state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN);
      done   <= (state_next == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      dr <= narrow_now ? 2'd1 : 2'd0;
      dc <= narrow_now ? 2'd1 : 2'd0;
    end else if (state == S_SCAN) begin
      if (dc == 2'd2) begin
        dc <= 2'd0;
        dr <= dr + 2'd1;
      end else begin
        dc <= dc + 2'd1;
      end
    end
  end

  // Accumulation and division by nine.
  always_ff @(posedge clk) begin
    if (rd_go) begin
      sum <= '0;
    end else if (rd_vld) begin
      sum <= sum + tba3_pkg::SUM_W'(signed'(ram_rdata));
    end
  end

  assign prod = tba3_pkg::PROD_W'(mag) * tba3_pkg::PROD_W'(tba3_pkg::RECIP_NINE);
  assign quot = prod[tba3_pkg::RECIP_SHIFT +: tba3_pkg::PIX_W];

  always_ff @(posedge clk) begin
    if (state == S_MAG) begin
      neg <= sum[tba3_pkg::SUM_W-1];
      mag <= sum[tba3_pkg::SUM_W-1] ? tba3_pkg::MAG_W'(-sum) : tba3_pkg::MAG_W'(sum);
      if (narrow) begin
        average_value <= sum[tba3_pkg::PIX_W-1:0];
      end
    end
    if (state == S_MUL) begin
      average_value <= neg ? -signed'(quot) : signed'(quot);
    end
  end

`ifndef NO_ASSERTIONS
  a_read_goes_busy: assert property (@(posedge clk) disable iff (rst)
    rd_go |=> busy)
    else $error("read request did not start the sequencer");

  a_write_stays_free: assert property (@(posedge clk) disable iff (rst)
    wr_go |=> !busy)
    else $error("write request made the unit busy");

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("result strobe not followed by idle");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && last_issue |=> (state == S_DRAIN) && rd_vld)
    else $error("neighbour fetch did not end in drain");

  a_done_needs_read: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");
`endif

endmodule

// ===== src/tba3_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module tba3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
